/* design/teq_pkg.sv */
// ---------------------------------------------------------------------------
// Timer expiry queue package
// Shared widths, codes and types for the timer expiry queue.
// ---------------------------------------------------------------------------
package teq_pkg;

  localparam int QueueDepth = 16;
  localparam int TickWidth  = 64;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int SeqW       = 32;
  localparam int TpmW       = 10;
  localparam int IdW        = 8;
  localparam int DurW       = 16;
  localparam int KindW      = 2;
  localparam int PendW      = 5;

  typedef enum logic [KindW-1:0] {
    EV_ACCEPTED = 2'd0,
    EV_REJECTED = 2'd1,
    EV_EXPIRED  = 2'd2
  } event_kind_t;

  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [IdW-1:0]        timer_id;
    logic [DurW+TpmW-1:0]  delta;
  } cmd_t;

  typedef struct packed {
    logic [KindW-1:0] event_kind;
    logic [IdW-1:0]   event_id;
    logic [PendW-1:0] pending_count;
  } result_t;

endpackage

/* design/teq_if.sv */
// ---------------------------------------------------------------------------
// Timer expiry queue channel interfaces
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface teq_in_if import teq_pkg::*; (input logic clk);
  logic            valid;
  logic            ready;
  logic            func;
  logic [IdW-1:0]  timer_id;
  logic [DurW-1:0] duration_ms;
  modport source (output valid, func, timer_id, duration_ms, input ready);
  modport sink   (input valid, func, timer_id, duration_ms, output ready);
endinterface

interface teq_out_if import teq_pkg::*; (input logic clk);
  logic             valid;
  logic             ready;
  logic [KindW-1:0] event_kind;
  logic [IdW-1:0]   event_id;
  logic [PendW-1:0] pending_count;
  modport source (output valid, event_kind, event_id, pending_count, input ready);
  modport sink   (input valid, event_kind, event_id, pending_count, output ready);
endinterface

/* design/teq_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module teq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/teq_front.sv */
// ---------------------------------------------------------------------------
// Timer expiry queue front end
// Accepts items and computes the duration in ticks, then queues the command.
// ---------------------------------------------------------------------------
module teq_front import teq_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [TpmW-1:0] tpm,
  teq_in_if.sink         in_ch,
  output logic           cmd_valid,
  output cmd_t           cmd,
  input  logic           cmd_pop
);
  // Two-entry queue.
  cmd_t       q_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       c;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rd_r];

  always_comb begin
    c.func     = in_ch.func;
    c.timer_id = in_ch.timer_id;
    c.delta    = (DurW+TpmW)'(in_ch.duration_ms) * (DurW+TpmW)'(tpm);
    rd_nxt  = rd_r ^ cmd_pop;
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_r] <= c;
    end
  end
endmodule

/* design/teq_back.sv */
// ---------------------------------------------------------------------------
// Timer expiry queue back end
// Holds the tick count and timer store, scans for the earliest timer and
// drives the result register.
// ---------------------------------------------------------------------------
module teq_back import teq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  teq_out_if.source out_ch
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CHECK, S_MOVE, S_OUT} state_t;

  localparam int EntW = TickWidth + IdW + SeqW;

  state_t              state_r;
  logic [TickWidth-1:0] tick_r;
  logic [SeqW-1:0]     seq_r;
  logic [CntW-1:0]     count_r;
  logic [CntW-1:0]     scan_r;
  logic                rvalid_r;
  logic [IdxW-1:0]     ridx_r;
  logic [IdxW-1:0]     best_r;
  logic [TickWidth-1:0] best_exp_r;
  logic [IdW-1:0]      best_id_r;
  logic [SeqW-1:0]     best_age_r;
  result_t             res_r;
  logic                ovalid_r;

  logic                we;
  logic [IdxW-1:0]     waddr, raddr;
  logic [EntW-1:0]     wdata, rdata;
  logic [TickWidth-1:0] r_exp;
  logic [IdW-1:0]      r_id;
  logic [SeqW-1:0]     r_age;
  logic                better;

  teq_ram #(.Width(EntW), .Depth(QueueDepth)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign r_exp  = rdata[EntW-1 -: TickWidth];
  assign r_id   = rdata[SeqW +: IdW];
  assign r_age  = seq_r - rdata[SeqW-1:0];
  assign better = (r_exp < best_exp_r) || (r_exp == best_exp_r && r_age > best_age_r);

  assign out_ch.valid         = ovalid_r;
  assign out_ch.event_kind    = res_r.event_kind;
  assign out_ch.event_id      = res_r.event_id;
  assign out_ch.pending_count = res_r.pending_count;

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid && !ovalid_r;

  always_comb begin
    we    = 1'b0;
    waddr = count_r[IdxW-1:0];
    wdata = {tick_r + TickWidth'(cmd.delta), cmd.timer_id, seq_r};
    raddr = scan_r[IdxW-1:0];
    if (cmd_pop && cmd.func == FUNC_INSERT && count_r != CntW'(QueueDepth)) begin
      we = 1'b1;
    end
    if (state_r == S_MOVE) begin
      raddr = count_r[IdxW-1:0];
    end
    if (state_r == S_OUT) begin
      we    = (best_r != count_r[IdxW-1:0]);
      waddr = best_r;
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tick_r   <= '0;
      seq_r    <= '0;
      count_r  <= '0;
      scan_r   <= '0;
      rvalid_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            if (cmd.func == FUNC_INSERT) begin
              ovalid_r           <= 1'b1;
              res_r.event_id     <= cmd.timer_id;
              if (count_r == CntW'(QueueDepth)) begin
                res_r.event_kind    <= EV_REJECTED;
                res_r.pending_count <= PendW'(count_r);
              end else begin
                res_r.event_kind    <= EV_ACCEPTED;
                res_r.pending_count <= PendW'(count_r + 1'b1);
                count_r             <= count_r + 1'b1;
                seq_r               <= seq_r + 1'b1;
              end
            end else begin
              tick_r <= tick_r + 1'b1;
              if (count_r != '0) begin
                state_r    <= S_SCAN;
                scan_r     <= '0;
                rvalid_r   <= 1'b0;
                best_exp_r <= '1;
                best_age_r <= '0;
                best_r     <= '0;
              end
            end
          end
        end
        S_SCAN: begin
          rvalid_r <= (scan_r < count_r);
          ridx_r   <= scan_r[IdxW-1:0];
          if (scan_r < count_r) begin
            scan_r <= scan_r + 1'b1;
          end
          if (rvalid_r && (better || ridx_r == '0)) begin
            best_r     <= ridx_r;
            best_exp_r <= r_exp;
            best_id_r  <= r_id;
            best_age_r <= r_age;
          end
          if (rvalid_r && !(scan_r < count_r)) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (best_exp_r > tick_r) begin
            state_r <= S_IDLE;
          end else begin
            count_r <= count_r - 1'b1;
            state_r <= S_MOVE;
          end
        end
        S_MOVE: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          ovalid_r            <= 1'b1;
          res_r.event_kind    <= EV_EXPIRED;
          res_r.event_id      <= best_id_r;
          res_r.pending_count <= PendW'(count_r);
          state_r             <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/timer_expiry_queue.sv */
// ---------------------------------------------------------------------------
// Timer expiry queue
// Tick counter with a store of pending timers; reports inserts and expiries.
// ---------------------------------------------------------------------------
// Items arrive on the in_ channel: func selects a tick or an insert of a
// timer with timer_id and duration_ms. Each insert gives one result item
// (accepted or rejected when 16 timers are pending); a tick gives a result
// item only when the earliest timer has fallen due. Ties leave in insertion
// order. cfg_we with cfg_wdata sets ticks per millisecond.
// The front end accepts items into a two-entry command queue and computes
// the duration in ticks. The back end handles one item at a time: an insert
// is handled in the idle state; a tick scans the store one entry a cycle
// through its registered read port, then removes the earliest timer if due.
// A result waits in an output register; while the receiver stalls, the back
// end holds and the front queue fills, then in_ready falls.
// Reset clears the tick count, the pending count and sets the multiplier
// to one; stored timers are discarded.
// ---------------------------------------------------------------------------
module timer_expiry_queue import teq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [TpmW-1:0] cfg_wdata,
  teq_in_if.sink          in_ch,
  teq_out_if.source       out_ch
);
  logic [TpmW-1:0] tpm_r;
  logic            cmd_valid, cmd_pop;
  cmd_t            cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r <= TpmW'(1);
    end else if (cfg_we) begin
      tpm_r <= cfg_wdata;
    end
  end

  teq_front u_front (
    .clk(clk), .rst_n(rst_n), .tpm(tpm_r), .in_ch(in_ch),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  teq_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_pop(cmd_pop), .out_ch(out_ch)
  );
endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// Timer expiry queue testbench
// Drives ticks and timer inserts with random gaps and receiver stalls, and
// predicts accept, reject and expiry items from its own copy of the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import teq_pkg::*;

  typedef struct {
    logic            func;
    logic [IdW-1:0]  timer_id;
    logic [DurW-1:0] duration_ms;
  } timer_cmd_t;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   id;
    logic [PendW-1:0] pending;
  } timer_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [TpmW-1:0] cfg_wdata = '0;

  teq_in_if  in_ch (clk);
  teq_out_if out_ch (clk);

  timer_expiry_queue u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_we (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model state
  logic [TickWidth-1:0] now_tick;
  logic [TickWidth-1:0] due_tick [QueueDepth];
  logic [IdW-1:0]       owner_of [QueueDepth];
  logic [SeqW-1:0]      stamp_of [QueueDepth];
  logic [SeqW-1:0]      next_stamp;
  int                   pending_n;
  logic [TpmW-1:0]      ticks_per_ms;

  timer_cmd_t   pending_cmds [$];
  timer_event_t expected_events [$];
  int  mismatches = 0;
  bit  hold_sender = 1'b0;

  task automatic predict_timer(input timer_cmd_t c);
    timer_event_t ev;
    int best;
    logic [SeqW-1:0] age_i, age_b;
    if (c.func == FUNC_INSERT) begin
      if (pending_n >= QueueDepth) begin
        ev.kind = EV_REJECTED;
      end else begin
        due_tick[pending_n] = now_tick + TickWidth'(c.duration_ms) * TickWidth'(ticks_per_ms);
        owner_of[pending_n] = c.timer_id;
        stamp_of[pending_n] = next_stamp;
        next_stamp++;
        pending_n++;
        ev.kind = EV_ACCEPTED;
      end
      ev.id = c.timer_id;
      ev.pending = PendW'(pending_n);
      expected_events.push_back(ev);
    end else begin
      now_tick++;
      if (pending_n == 0) return;
      best = 0;
      for (int i = 1; i < pending_n; i++) begin
        age_i = next_stamp - stamp_of[i];
        age_b = next_stamp - stamp_of[best];
        if (due_tick[i] < due_tick[best] ||
            (due_tick[i] == due_tick[best] && age_i > age_b)) best = i;
      end
      if (due_tick[best] > now_tick) return;
      ev.kind = EV_EXPIRED;
      ev.id = owner_of[best];
      pending_n--;
      due_tick[best] = due_tick[pending_n];
      owner_of[best] = owner_of[pending_n];
      stamp_of[best] = stamp_of[pending_n];
      ev.pending = PendW'(pending_n);
      expected_events.push_back(ev);
    end
  endtask

  // Driver
  int send_gap = 0;
  bit in_taken = 1'b0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_TICK;
    in_ch.timer_id = '0;
    in_ch.duration_ms = '0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_timer('{in_ch.func, in_ch.timer_id, in_ch.duration_ms});
    end
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin
    timer_cmd_t c;
    if (rst_n && in_taken) begin
      in_ch.valid <= 1'b0;
      send_gap <= $urandom_range(0, 13);
    end else if (rst_n && !in_ch.valid && !hold_sender && pending_cmds.size() > 0) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else begin
        c = pending_cmds.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= c.func;
        in_ch.timer_id <= c.timer_id;
        in_ch.duration_ms <= c.duration_ms;
      end
    end
  end

  // Monitor
  int stall = 0;
  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    timer_event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: kind %0d id %0d pending %0d",
                   out_ch.event_kind, out_ch.event_id, out_ch.pending_count);
      end else begin
        want = expected_events.pop_front();
        if (want.kind !== out_ch.event_kind || want.id !== out_ch.event_id ||
            want.pending !== out_ch.pending_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("item mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                     want.kind, want.id, want.pending, out_ch.event_kind,
                     out_ch.event_id, out_ch.pending_count);
        end
      end
      stall = $urandom_range(0, 13);
    end
    #10;
    if (stall > 0) begin
      stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic timer_cmd_t make_tick();
    timer_cmd_t c;
    c.func = FUNC_TICK;
    c.timer_id = IdW'($urandom);
    c.duration_ms = DurW'($urandom);
    return c;
  endfunction

  function automatic timer_cmd_t make_insert(input logic [DurW-1:0] d);
    timer_cmd_t c;
    c.func = FUNC_INSERT;
    c.timer_id = IdW'($urandom);
    c.duration_ms = d;
    return c;
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || in_ch.valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_rate(input logic [TpmW-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    ticks_per_ms = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [TpmW-1:0] rates [5];
    logic [DurW-1:0] d;
    int r;
    now_tick = '0;
    next_stamp = '0;
    pending_n = 0;
    ticks_per_ms = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty tick, zero duration, ties, fill past full, extreme fields.
    pending_cmds.push_back(make_tick());
    pending_cmds.push_back(make_insert(16'd0));
    pending_cmds.push_back(make_tick());
    pending_cmds.push_back(make_insert(16'hFFFF));
    for (int i = 0; i < 16; i++) pending_cmds.push_back(make_insert(16'd2));
    pending_cmds.push_back('{FUNC_INSERT, 8'hFF, 16'hFFFF});
    pending_cmds.push_back('{FUNC_INSERT, 8'h00, 16'h0000});
    pending_cmds.push_back(make_tick());
    pending_cmds.push_back(make_tick());
    drain();
    for (int i = 0; i < 20; i++) pending_cmds.push_back(make_tick());
    drain();

    rates = '{10'd0, 10'd1000, 10'd3, 10'd1023, 10'd1};
    for (int p = 0; p < 5; p++) begin
      set_rate(rates[p]);
      for (int n = 0; n < 400; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          pending_cmds.push_back(make_tick());
        end else begin
          if (r < 85) d = DurW'($urandom_range(0, 8));
          else if (r < 95) d = DurW'($urandom_range(0, 40));
          else d = DurW'($urandom);
          pending_cmds.push_back(make_insert(d));
        end
      end
      if (p == 2) begin
        while (pending_cmds.size() > 200) @(posedge clk);
        hold_sender = 1'b1;
        while (in_ch.valid || expected_events.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
      // Send ticks to expire timers that fall due soon; long timers stay pending.
      for (int n = 0; n < 30; n++) pending_cmds.push_back(make_tick());
      drain();
    end

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

/* sim.f */
design/teq_pkg.sv
design/teq_if.sv
design/teq_ram.sv
design/teq_front.sv
design/teq_back.sv
design/timer_expiry_queue.sv
tb/tb.sv
